// ===== hdl/ulpi_pd_pkg.sv =====
// Package for the ULPI receive packet decoder: status, class and pid codes, the
// result record and the CRC step functions. It depends on nothing else.
package ulpi_pd_pkg;

    localparam int unsigned COUNT_W = 11;
    localparam logic [COUNT_W-1:0] MAX_PACKET_BYTES = 11'd1027;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 11'h7ff;

    localparam logic [1:0] EV_RX_ACTIVE = 2'd1;
    localparam logic [1:0] EV_RX_ERROR  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_PID    = 3'd1;
    localparam logic [2:0] ST_PID_CHECK = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_RESERVED  = 3'd4;
    localparam logic [2:0] ST_CRC_BAD   = 3'd5;
    localparam logic [2:0] ST_TOO_LONG  = 3'd6;

    localparam logic [1:0] CLS_HANDSHAKE = 2'd0;
    localparam logic [1:0] CLS_DATA      = 2'd1;
    localparam logic [1:0] CLS_TOKEN     = 2'd2;
    localparam logic [1:0] CLS_SOF       = 2'd3;

    localparam logic [7:0] PID_OUT   = 8'he1;
    localparam logic [7:0] PID_IN    = 8'h69;
    localparam logic [7:0] PID_SETUP = 8'h2d;
    localparam logic [7:0] PID_PING  = 8'hb4;
    localparam logic [7:0] PID_DATA0 = 8'hc3;
    localparam logic [7:0] PID_DATA1 = 8'h4b;
    localparam logic [7:0] PID_DATA2 = 8'h87;
    localparam logic [7:0] PID_MDATA = 8'h0f;
    localparam logic [7:0] PID_ACK   = 8'hd2;
    localparam logic [7:0] PID_NAK   = 8'h5a;
    localparam logic [7:0] PID_STALL = 8'h1e;
    localparam logic [7:0] PID_NYET  = 8'h96;
    localparam logic [7:0] PID_SOF   = 8'ha5;

    localparam logic [4:0] CRC5_INIT = 5'h1f;
    localparam logic [4:0] CRC5_RESIDUAL = 5'h0c;
    localparam logic [4:0] CRC5_POLY = 5'h05;
    localparam logic [15:0] CRC16_INIT = 16'hffff;
    localparam logic [15:0] CRC16_RESIDUAL = 16'hb001;
    localparam logic [15:0] CRC16_POLY = 16'ha001;

    localparam int unsigned TDATA_W = 48;

    typedef struct packed {
        logic                rx_error;
        logic [COUNT_W-1:0]  byte_count;
        logic [10:0]         frame_number;
        logic [3:0]          endpoint;
        logic [6:0]          device_address;
        logic [3:0]          pid;
        logic [2:0]          status;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC16_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] crc5_byte(input logic [4:0] crc, input logic [7:0] b);
        logic [4:0] r;
        logic       fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[4] ^ b[i];
            r  = {r[3:0], 1'b0};
            if (fb) begin
                r = r ^ CRC5_POLY;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/ulpi_usb_packet_decoder_unit.sv =====
// Top level of the ULPI receive packet decoder.
// Depends on ulpi_pd_pkg for codes, the result record and the CRC steps.
//
// Usage: the slave stream carries one ULPI bus cycle per transaction, the
// data byte in tdata and the dir and nxt lines in tuser. Cycles in which dir
// changed or is low are dropped. An RXCMD with RxActive opens a packet; data
// cycles collect bytes, one per transaction, with CRC16 over every byte after
// the pid and CRC5 over the two after it. Any other RXCMD closes the packet and
// puts one summary on the master stream, unless it holds an SOF pid while SOF
// enable is clear. The class goes out in tuser, all other fields in tdata.
// Throughput: one bus cycle per clock while tready is high, set by the single
// byte step of the packet state registers. The master side has an output
// register and a skid register, the latter filled when the output register
// is stalled, so a stalled receiver costs input cycles only once both hold a
// summary; tready on the slave side then drops until the skid register drains.
// The SOF enable register is written through the cfg channel, which is always
// ready. A synchronous active-low reset closes any packet, clears the SOF
// enable and empties both output registers.
module ulpi_usb_packet_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // sof_enable
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // bus_data
    input  logic [1:0]  i_s_tuser,      // bus_dir, bus_nxt
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status, pid, device_address, endpoint, frame_number, byte_count,
    // rx_error, zero fill
    output logic [ulpi_pd_pkg::TDATA_W-1:0] o_m_tdata,
    output logic [1:0]  o_m_tuser       // packet_class
);

    logic        r_sof_enable;
    logic        r_prev_dir;
    logic        r_open;
    logic [ulpi_pd_pkg::COUNT_W-1:0] r_count;
    logic [7:0]  r_pid_byte;
    logic [7:0]  r_byte1;
    logic [7:0]  r_byte2;
    logic [15:0] r_crc16;
    logic [4:0]  r_crc5;

    logic        r_out_valid;
    ulpi_pd_pkg::t_result r_out;
    logic [1:0]  r_out_cls;
    logic        r_skid_valid;
    ulpi_pd_pkg::t_result r_skid;
    logic [1:0]  r_skid_cls;

    logic        acc;
    logic        dir;
    logic        nxt;
    logic [1:0]  rx_event;
    logic        live;
    logic        is_data;
    logic        is_close;
    logic        res_valid;
    logic        out_fire;
    ulpi_pd_pkg::t_result res;
    logic [1:0]  res_cls;
    logic        pid_ok;
    logic        long3;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign acc         = i_s_tvalid && o_s_tready;
    assign dir         = i_s_tuser[0];
    assign nxt         = i_s_tuser[1];
    assign rx_event    = i_s_tdata[5:4];
    assign live        = acc && (dir == r_prev_dir) && dir;
    assign is_data     = live && nxt && r_open;
    assign is_close    = live && !nxt && (rx_event != ulpi_pd_pkg::EV_RX_ACTIVE) && r_open;
    assign out_fire    = r_out_valid && i_m_tready;

    always_comb begin
        res     = '0;
        res_cls = ulpi_pd_pkg::CLS_HANDSHAKE;
        pid_ok  = (r_pid_byte[7:4] == ~r_pid_byte[3:0]);
        long3   = (r_count >= ulpi_pd_pkg::COUNT_W'(3));
        res.byte_count = r_count;
        res.rx_error   = (rx_event == ulpi_pd_pkg::EV_RX_ERROR);
        res.pid        = r_pid_byte[3:0];
        res.status     = ulpi_pd_pkg::ST_OK;
        if (r_count == '0) begin
            res.status = ulpi_pd_pkg::ST_NO_PID;
            res.pid    = 4'h0;
        end else if (!pid_ok) begin
            res.status = ulpi_pd_pkg::ST_PID_CHECK;
        end else begin
            case (r_pid_byte)
                ulpi_pd_pkg::PID_ACK, ulpi_pd_pkg::PID_NAK,
                ulpi_pd_pkg::PID_STALL, ulpi_pd_pkg::PID_NYET: begin
                    res_cls = ulpi_pd_pkg::CLS_HANDSHAKE;
                end
                ulpi_pd_pkg::PID_DATA0, ulpi_pd_pkg::PID_DATA1,
                ulpi_pd_pkg::PID_DATA2, ulpi_pd_pkg::PID_MDATA: begin
                    res_cls = ulpi_pd_pkg::CLS_DATA;
                end
                ulpi_pd_pkg::PID_OUT, ulpi_pd_pkg::PID_IN,
                ulpi_pd_pkg::PID_SETUP, ulpi_pd_pkg::PID_PING: begin
                    res_cls = ulpi_pd_pkg::CLS_TOKEN;
                end
                ulpi_pd_pkg::PID_SOF:       res_cls = ulpi_pd_pkg::CLS_SOF;
                default:                    res.status = ulpi_pd_pkg::ST_RESERVED;
            endcase
            if (res.status == ulpi_pd_pkg::ST_OK) begin
                if (r_count > ulpi_pd_pkg::MAX_PACKET_BYTES) begin
                    res.status = ulpi_pd_pkg::ST_TOO_LONG;
                end else if (res_cls != ulpi_pd_pkg::CLS_HANDSHAKE && !long3) begin
                    res.status = ulpi_pd_pkg::ST_SHORT;
                end
            end
            if (res_cls == ulpi_pd_pkg::CLS_TOKEN && long3) begin
                res.device_address = r_byte1[6:0];
                res.endpoint       = {r_byte2[2:0], r_byte1[7]};
            end
            if (res_cls == ulpi_pd_pkg::CLS_SOF && long3) begin
                res.frame_number = {r_byte2[2:0], r_byte1};
            end
            if (res.status == ulpi_pd_pkg::ST_OK) begin
                if (res_cls == ulpi_pd_pkg::CLS_DATA
                    && r_crc16 != ulpi_pd_pkg::CRC16_RESIDUAL) begin
                    res.status = ulpi_pd_pkg::ST_CRC_BAD;
                end else if ((res_cls == ulpi_pd_pkg::CLS_TOKEN
                              || res_cls == ulpi_pd_pkg::CLS_SOF)
                             && r_crc5 != ulpi_pd_pkg::CRC5_RESIDUAL) begin
                    res.status = ulpi_pd_pkg::ST_CRC_BAD;
                end
            end
        end
        res_valid = is_close && !(r_count != '0 && !r_sof_enable
                                  && r_pid_byte == ulpi_pd_pkg::PID_SOF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_sof_enable <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dir <= 1'b0;
            r_open     <= 1'b0;
            r_count    <= '0;
            r_pid_byte <= 8'h00;
            r_byte1    <= 8'h00;
            r_byte2    <= 8'h00;
            r_crc16    <= ulpi_pd_pkg::CRC16_INIT;
            r_crc5     <= ulpi_pd_pkg::CRC5_INIT;
        end else begin
            if (acc) begin
                r_prev_dir <= dir;
            end
            if (is_data) begin
                if (r_count == '0) begin
                    r_pid_byte <= i_s_tdata;
                end else begin
                    r_crc16 <= ulpi_pd_pkg::crc16_byte(r_crc16, i_s_tdata);
                end
                if (r_count == ulpi_pd_pkg::COUNT_W'(1)) begin
                    r_byte1 <= i_s_tdata;
                    r_crc5  <= ulpi_pd_pkg::crc5_byte(r_crc5, i_s_tdata);
                end
                if (r_count == ulpi_pd_pkg::COUNT_W'(2)) begin
                    r_byte2 <= i_s_tdata;
                    r_crc5  <= ulpi_pd_pkg::crc5_byte(r_crc5, i_s_tdata);
                end
                if (r_count != ulpi_pd_pkg::COUNT_SAT) begin
                    r_count <= r_count + ulpi_pd_pkg::COUNT_W'(1);
                end
            end
            if (live && !nxt && rx_event == ulpi_pd_pkg::EV_RX_ACTIVE && !r_open) begin
                r_open     <= 1'b1;
                r_count    <= '0;
                r_pid_byte <= 8'h00;
                r_byte1    <= 8'h00;
                r_byte2    <= 8'h00;
                r_crc16    <= ulpi_pd_pkg::CRC16_INIT;
                r_crc5     <= ulpi_pd_pkg::CRC5_INIT;
            end
            if (is_close) begin
                r_open <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (res_valid) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                    r_out       <= res;
                    r_out_cls   <= res_cls;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid       <= res;
                    r_skid_cls   <= res_cls;
                end
            end else if (out_fire) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_cls    <= r_skid_cls;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(ulpi_pd_pkg::TDATA_W - $bits(ulpi_pd_pkg::t_result)){1'b0}}, r_out};
    assign o_m_tuser  = r_out_cls;

endmodule

// ===== hdl/ulpi_pd_checker.sv =====
// Port-level checker for the ULPI receive packet decoder, bound to the top
// level. Depends on ulpi_pd_pkg and on ulpi_usb_packet_decoder_unit.
module ulpi_pd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [ulpi_pd_pkg::TDATA_W-1:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("Stalled summary changed.");

    a_no_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[2:0] == ulpi_pd_pkg::ST_NO_PID
        |-> i_m_tdata[39:29] == '0 && i_m_tdata[6:3] == 4'h0
            && i_m_tuser == ulpi_pd_pkg::CLS_HANDSHAKE)
        else $error("Packet without pid reports bytes or a pid.");

    a_token_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser != ulpi_pd_pkg::CLS_TOKEN
        |-> i_m_tdata[17:7] == '0)
        else $error("Address or endpoint set on a non-token packet.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("Summary valid after reset.");

endmodule

bind ulpi_usb_packet_decoder_unit ulpi_pd_checker u_ulpi_pd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

// ===== sim/tb_ulpi_usb_packet_decoder_unit.sv =====
// Testbench for ulpi_usb_packet_decoder_unit: ULPI bus cycles go in on the slave stream and the
// packet summaries are predicted and checked field by field. It depends on ulpi_pd_pkg and the
// decoder RTL only.
module tb_ulpi_usb_packet_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_OTHER = 2'd3;

    localparam logic [7:0] PID_RSVD  = 8'hf0;
    localparam logic [7:0] PID_SPLIT = 8'h78;
    localparam logic [7:0] PID_PRE   = 8'h3c;

    localparam logic [7:0] TOKEN_PIDS [4] = '{ulpi_pd_pkg::PID_OUT, ulpi_pd_pkg::PID_IN,
                                              ulpi_pd_pkg::PID_SETUP, ulpi_pd_pkg::PID_PING};
    localparam logic [7:0] DATA_PIDS [4] = '{ulpi_pd_pkg::PID_DATA0, ulpi_pd_pkg::PID_DATA1,
                                             ulpi_pd_pkg::PID_DATA2, ulpi_pd_pkg::PID_MDATA};
    localparam logic [7:0] HANDSHAKE_PIDS [4] = '{ulpi_pd_pkg::PID_ACK, ulpi_pd_pkg::PID_NAK,
                                                  ulpi_pd_pkg::PID_STALL, ulpi_pd_pkg::PID_NYET};
    localparam logic [7:0] RESERVED_PIDS [3] = '{PID_RSVD, PID_SPLIT, PID_PRE};

    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        ulpi_pd_pkg::t_result fields;
        logic [1:0]           cls;
    } t_packet_summary;

    class t_summary_board;
        bit              sof_enable;
        bit              dir_seen;
        bit              in_packet;
        logic [10:0]     rx_count;
        logic [7:0]      pid_b;
        logic [7:0]      byte1;
        logic [7:0]      byte2;
        logic [15:0]     crc16;
        t_packet_summary summaries_due[$];
        int              mismatches;

        function new();
            sof_enable = 1'b0;
            dir_seen = 1'b0;
            in_packet = 1'b0;
            rx_count = '0;
            pid_b = '0;
            byte1 = '0;
            byte2 = '0;
            crc16 = ulpi_pd_pkg::CRC16_INIT;
            mismatches = 0;
        endfunction

        static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                r = r[0] ? ((r >> 1) ^ ulpi_pd_pkg::CRC16_POLY) : (r >> 1);
            end
            return r;
        endfunction

        static function bit crc5_ok(logic [15:0] w);
            logic [4:0] r;
            logic       fb;
            r = ulpi_pd_pkg::CRC5_INIT;
            for (int i = 0; i < 16; i++) begin
                fb = r[4] ^ w[i];
                r = {r[3:0], 1'b0};
                if (fb) begin
                    r = r ^ ulpi_pd_pkg::CRC5_POLY;
                end
            end
            return r == ulpi_pd_pkg::CRC5_RESIDUAL;
        endfunction

        // Returns 1 when the bus cycle is not simply dropped by the decoder.
        function bit take_bus_cycle(bit dir, bit nxt, logic [7:0] data);
            t_packet_summary s;
            logic [1:0]      ev;
            logic [15:0]     w;
            bit              turned;
            turned = dir != dir_seen;
            dir_seen = dir;
            if (turned || !dir) begin
                return 1'b0;
            end
            if (nxt) begin
                if (!in_packet) begin
                    return 1'b0;
                end
                if (rx_count == 0) begin
                    pid_b = data;
                end else begin
                    if (rx_count == 1) begin
                        byte1 = data;
                    end else if (rx_count == 2) begin
                        byte2 = data;
                    end
                    crc16 = crc16_step(crc16, data);
                end
                if (rx_count != ulpi_pd_pkg::COUNT_SAT) begin
                    rx_count = rx_count + 1'b1;
                end
                return 1'b1;
            end
            ev = data[5:4];
            if (ev == ulpi_pd_pkg::EV_RX_ACTIVE) begin
                if (!in_packet) begin
                    in_packet = 1'b1;
                    rx_count = '0;
                    pid_b = '0;
                    byte1 = '0;
                    byte2 = '0;
                    crc16 = ulpi_pd_pkg::CRC16_INIT;
                end
                return 1'b1;
            end
            if (!in_packet) begin
                return 1'b0;
            end
            in_packet = 1'b0;
            if (rx_count != 0 && !sof_enable && pid_b == ulpi_pd_pkg::PID_SOF) begin
                return 1'b1;
            end
            s = '0;
            s.cls = ulpi_pd_pkg::CLS_HANDSHAKE;
            s.fields.pid = pid_b[3:0];
            s.fields.byte_count = rx_count;
            s.fields.rx_error = (ev == ulpi_pd_pkg::EV_RX_ERROR);
            s.fields.status = ulpi_pd_pkg::ST_OK;
            w = {byte2, byte1};
            if (rx_count == 0) begin
                s.fields.status = ulpi_pd_pkg::ST_NO_PID;
                s.fields.pid = '0;
            end else if (pid_b[7:4] != ~pid_b[3:0]) begin
                s.fields.status = ulpi_pd_pkg::ST_PID_CHECK;
            end else begin
                case (pid_b)
                    ulpi_pd_pkg::PID_ACK, ulpi_pd_pkg::PID_NAK,
                    ulpi_pd_pkg::PID_STALL, ulpi_pd_pkg::PID_NYET: begin
                        s.cls = ulpi_pd_pkg::CLS_HANDSHAKE;
                    end
                    ulpi_pd_pkg::PID_DATA0, ulpi_pd_pkg::PID_DATA1,
                    ulpi_pd_pkg::PID_DATA2, ulpi_pd_pkg::PID_MDATA: begin
                        s.cls = ulpi_pd_pkg::CLS_DATA;
                    end
                    ulpi_pd_pkg::PID_OUT, ulpi_pd_pkg::PID_IN,
                    ulpi_pd_pkg::PID_SETUP, ulpi_pd_pkg::PID_PING: begin
                        s.cls = ulpi_pd_pkg::CLS_TOKEN;
                    end
                    ulpi_pd_pkg::PID_SOF: s.cls = ulpi_pd_pkg::CLS_SOF;
                    default: s.fields.status = ulpi_pd_pkg::ST_RESERVED;
                endcase
                if (s.fields.status == ulpi_pd_pkg::ST_OK) begin
                    if (rx_count > ulpi_pd_pkg::MAX_PACKET_BYTES) begin
                        s.fields.status = ulpi_pd_pkg::ST_TOO_LONG;
                    end else if (s.cls != ulpi_pd_pkg::CLS_HANDSHAKE && rx_count < 3) begin
                        s.fields.status = ulpi_pd_pkg::ST_SHORT;
                    end
                end
                if (s.cls == ulpi_pd_pkg::CLS_TOKEN && rx_count >= 3) begin
                    s.fields.device_address = w[6:0];
                    s.fields.endpoint = w[10:7];
                end
                if (s.cls == ulpi_pd_pkg::CLS_SOF && rx_count >= 3) begin
                    s.fields.frame_number = w[10:0];
                end
                if (s.fields.status == ulpi_pd_pkg::ST_OK) begin
                    if (s.cls == ulpi_pd_pkg::CLS_DATA
                        && crc16 != ulpi_pd_pkg::CRC16_RESIDUAL) begin
                        s.fields.status = ulpi_pd_pkg::ST_CRC_BAD;
                    end else if ((s.cls == ulpi_pd_pkg::CLS_TOKEN
                                  || s.cls == ulpi_pd_pkg::CLS_SOF) && !crc5_ok(w)) begin
                        s.fields.status = ulpi_pd_pkg::ST_CRC_BAD;
                    end
                end
            end
            summaries_due.push_back(s);
            return 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_summary(logic [ulpi_pd_pkg::TDATA_W-1:0] tdata, logic [1:0] tuser);
            t_packet_summary      want;
            ulpi_pd_pkg::t_result got;
            got = ulpi_pd_pkg::t_result'(tdata[$bits(ulpi_pd_pkg::t_result)-1:0]);
            if (summaries_due.size() == 0) begin
                $error("summary with none expected: tdata %h tuser %0d", tdata, tuser);
                mismatches++;
                return;
            end
            want = summaries_due.pop_front();
            compare_field("status", 32'(want.fields.status), 32'(got.status));
            compare_field("pid", 32'(want.fields.pid), 32'(got.pid));
            compare_field("packet_class", 32'(want.cls), 32'(tuser));
            compare_field("device_address", 32'(want.fields.device_address),
                          32'(got.device_address));
            compare_field("endpoint", 32'(want.fields.endpoint), 32'(got.endpoint));
            compare_field("frame_number", 32'(want.fields.frame_number),
                          32'(got.frame_number));
            compare_field("byte_count", 32'(want.fields.byte_count), 32'(got.byte_count));
            compare_field("rx_error", 32'(want.fields.rx_error), 32'(got.rx_error));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_data;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;
    logic [1:0]          i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b1;
    logic [ulpi_pd_pkg::TDATA_W-1:0] o_m_tdata;
    logic [1:0]          o_m_tuser;

    t_summary_board    board = new();
    logic [7:0]        pkt[$];
    bit                bus_dir_now;
    int                gap_pct;
    int                stall_pct;
    int                cycles_used;

    ulpi_usb_packet_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_summary(o_m_tdata, o_m_tuser);
        end
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic drive_bus_cycle(input bit dir, input bit nxt, input logic [7:0] data);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= {nxt, dir};
        i_s_tdata <= data;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        if (board.take_bus_cycle(dir, nxt, data)) begin
            cycles_used++;
        end
        bus_dir_now = dir;
    endtask

    task automatic link_cycles(input int n);
        repeat (n) drive_bus_cycle(1'b0, 1'($urandom), 8'($urandom));
    endtask

    task automatic turn_to_phy();
        if (!bus_dir_now) begin
            drive_bus_cycle(1'b1, 1'($urandom), 8'($urandom));
        end
    endtask

    task automatic rx_cmd(input logic [1:0] ev);
        logic [7:0] b;
        b = 8'($urandom);
        b[5:4] = ev;
        drive_bus_cycle(1'b1, 1'b0, b);
    endtask

    task automatic noise_cycles(input int n);
        repeat (n) drive_bus_cycle(1'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_packet(input logic [1:0] close_ev, input bit rough);
        turn_to_phy();
        rx_cmd(ulpi_pd_pkg::EV_RX_ACTIVE);
        foreach (pkt[i]) begin
            if (rough && $urandom_range(0, 19) == 0) begin
                rx_cmd(ulpi_pd_pkg::EV_RX_ACTIVE);
            end
            if (rough && $urandom_range(0, 39) == 0) begin
                link_cycles($urandom_range(1, 3));
                turn_to_phy();
            end
            drive_bus_cycle(1'b1, 1'b1, pkt[i]);
        end
        rx_cmd(close_ev);
        if ($urandom_range(0, 1) == 1) begin
            link_cycles($urandom_range(1, 3));
        end
    endtask

    function automatic void build_token(logic [7:0] pid, logic [6:0] addr, logic [3:0] ep);
        logic [15:0] w;
        w = {5'd0, ep, addr};
        for (int h = 0; h < 32; h++) begin
            w[15:11] = h[4:0];
            if (t_summary_board::crc5_ok(w)) begin
                break;
            end
        end
        pkt = {pid, w[7:0], w[15:8]};
    endfunction

    function automatic void build_data(logic [7:0] pid, int len);
        logic [15:0] c;
        logic [7:0]  b;
        c = ulpi_pd_pkg::CRC16_INIT;
        pkt = {pid};
        repeat (len) begin
            b = 8'($urandom);
            pkt.push_back(b);
            c = t_summary_board::crc16_step(c, b);
        end
        c = ~c;
        pkt.push_back(c[7:0]);
        pkt.push_back(c[15:8]);
    endfunction

    function automatic void corrupt_pkt();
        int idx;
        idx = $urandom_range(1, pkt.size() - 1);
        pkt[idx][$urandom_range(0, 7)] ^= 1'b1;
    endfunction

    task automatic write_sof_enable(input bit value);
        i_s_tvalid <= 1'b0;
        while (board.summaries_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        board.sof_enable = value;
    endtask

    task automatic random_packet();
        int          r;
        logic [1:0]  ev;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: build_token(TOKEN_PIDS[$urandom_range(0, 3)], 7'($urandom), 4'($urandom));
            2: build_token(ulpi_pd_pkg::PID_SOF, 7'($urandom), 4'($urandom));
            3, 4: build_data(DATA_PIDS[$urandom_range(0, 3)], $urandom_range(0, 16));
            5: pkt = {HANDSHAKE_PIDS[$urandom_range(0, 3)]};
            6: begin
                pkt = {};
                repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
            end
            7: pkt = {};
            8: begin
                case ($urandom_range(0, 2))
                    0: pkt = {TOKEN_PIDS[$urandom_range(0, 3)]};
                    1: pkt = {DATA_PIDS[$urandom_range(0, 3)]};
                    default: pkt = {ulpi_pd_pkg::PID_SOF};
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    pkt.push_back(8'($urandom));
                end
            end
            default: begin
                pkt = {RESERVED_PIDS[$urandom_range(0, 2)]};
                repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
            end
        endcase
        if (pkt.size() > 1 && $urandom_range(0, 6) == 0) begin
            corrupt_pkt();
        end
        r = $urandom_range(0, 9);
        ev = (r == 0) ? ulpi_pd_pkg::EV_RX_ERROR : ((r == 1) ? EV_OTHER : EV_NONE);
        send_packet(ev, 1'b1);
    endtask

    task automatic random_traffic(input int goal);
        int used0;
        used0 = cycles_used;
        while (cycles_used - used0 < goal) begin
            if ($urandom_range(0, 99) < 8) begin
                noise_cycles($urandom_range(1, 6));
            end else begin
                random_packet();
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= '0;
        bus_dir_now = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        cycles_used = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_sof_enable(1'b0);
        link_cycles(2);
        turn_to_phy();
        drive_bus_cycle(1'b1, 1'b1, 8'hff);
        rx_cmd(EV_NONE);
        drive_bus_cycle(1'b1, 1'b1, 8'h00);
        pkt = {};
        send_packet(EV_NONE, 1'b0);
        pkt = {8'h12, 8'h34};
        send_packet(EV_NONE, 1'b0);
        foreach (RESERVED_PIDS[i]) begin
            pkt = {RESERVED_PIDS[i], 8'h00};
            send_packet(EV_NONE, 1'b0);
        end
        foreach (HANDSHAKE_PIDS[i]) begin
            pkt = {HANDSHAKE_PIDS[i]};
            send_packet(EV_NONE, 1'b0);
        end
        build_token(ulpi_pd_pkg::PID_OUT, 7'h7f, 4'hf);
        send_packet(EV_NONE, 1'b0);
        build_token(ulpi_pd_pkg::PID_IN, 7'h00, 4'h0);
        send_packet(ulpi_pd_pkg::EV_RX_ERROR, 1'b0);
        build_token(ulpi_pd_pkg::PID_SETUP, 7'h2a, 4'h5);
        corrupt_pkt();
        send_packet(EV_NONE, 1'b0);
        pkt = {ulpi_pd_pkg::PID_PING, 8'h81};
        send_packet(EV_OTHER, 1'b0);
        build_token(ulpi_pd_pkg::PID_SOF, 7'h7f, 4'hf);
        send_packet(EV_NONE, 1'b0);
        build_data(ulpi_pd_pkg::PID_DATA0, 0);
        send_packet(EV_NONE, 1'b1);
        build_data(ulpi_pd_pkg::PID_DATA1, 6);
        corrupt_pkt();
        send_packet(EV_NONE, 1'b0);
        build_data(ulpi_pd_pkg::PID_DATA2, 8);
        send_packet(EV_OTHER, 1'b1);
        pkt = {ulpi_pd_pkg::PID_MDATA, 8'hff};
        send_packet(EV_NONE, 1'b0);

        write_sof_enable(1'b1);
        build_token(ulpi_pd_pkg::PID_SOF, 7'h00, 4'h0);
        send_packet(EV_NONE, 1'b0);
        build_token(ulpi_pd_pkg::PID_SOF, 7'h55, 4'ha);
        corrupt_pkt();
        send_packet(EV_NONE, 1'b0);
        pkt = {ulpi_pd_pkg::PID_SOF};
        send_packet(ulpi_pd_pkg::EV_RX_ERROR, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 73; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 73; end
                default: begin gap_pct = 13; stall_pct = 13; end
            endcase
            write_sof_enable(ph % 2 == 0);
            random_traffic(70);
        end

        i_s_tvalid <= 1'b0;
        while (board.summaries_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("ulpi_usb_packet_decoder_unit test passed");
        end else begin
            $display("ulpi_usb_packet_decoder_unit test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("ulpi_usb_packet_decoder_unit test failed");
        $finish;
    end

endmodule

// ===== ulpi_usb_packet_decoder_unit.f =====
hdl/ulpi_pd_pkg.sv
hdl/ulpi_usb_packet_decoder_unit.sv
hdl/ulpi_pd_checker.sv
sim/tb_ulpi_usb_packet_decoder_unit.sv
